/* hw/rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BPCS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bpcs assertion failed");
`define BPCS_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bpcs forbidden condition");
`else
`define BPCS_ASSERT(label, prop)
`define BPCS_ASSERT_NEVER(label, expr)
`endif

`endif

/* hw/rtl/bpcs_pkg.sv */
package bpcs_pkg;

  localparam int ENTRY_W_BITS  = 5;
  localparam int MODE_BITS     = 2;
  localparam int VAL_BITS      = 31;
  localparam int COUNT_BITS    = 32;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [ENTRY_W_BITS-1:0] ENTRY_WIDTH_RESET = 5'd8;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_ENTRY_WIDTH  = 3'd0,
    REG_COMPARE_MODE = 3'd1,
    REG_LOW_VALUE    = 3'd2,
    REG_HIGH_VALUE   = 3'd3,
    REG_ENTRY_COUNT  = 3'd4
  } reg_idx_t;

  typedef enum logic [MODE_BITS-1:0] {
    CMP_EQ    = 2'd0,
    CMP_NE    = 2'd1,
    CMP_RANGE = 2'd2
  } cmp_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } scan_state_t;

  typedef struct packed {
    logic [ENTRY_W_BITS-1:0] entry_width;
    logic [MODE_BITS-1:0]    compare_mode;
    logic [VAL_BITS-1:0]     low_value;
    logic [VAL_BITS-1:0]     high_value;
    logic [COUNT_BITS-1:0]   entry_count;
    logic                    restart;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic clear;
  } win_ctrl_t;

endpackage

/* hw/rtl/bpcs_ifs.sv */
interface bpcs_word_if #(parameter int WORD_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] packed_word;

  modport source (output valid, output packed_word, input ready);
  modport sink (input valid, input packed_word, output ready);
endinterface

interface bpcs_result_if;
  logic        valid;
  logic        ready;
  logic        match;
  logic [31:0] entry_index;
  logic        last_entry;

  modport source (output valid, output match, output entry_index, output last_entry,
                  input ready);
  modport sink (input valid, input match, input entry_index, input last_entry,
                output ready);
endinterface

/* hw/rtl/bpcs_cfg.sv */
module bpcs_cfg import bpcs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic [ENTRY_W_BITS-1:0] entry_width_r;
  logic [MODE_BITS-1:0]    compare_mode_r;
  logic [VAL_BITS-1:0]     low_value_r;
  logic [VAL_BITS-1:0]     high_value_r;
  logic [COUNT_BITS-1:0]   entry_count_r;
  logic                    wr;
  reg_idx_t                idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_width_r  <= ENTRY_WIDTH_RESET;
      compare_mode_r <= '0;
      low_value_r    <= '0;
      high_value_r   <= '0;
      entry_count_r  <= '0;
    end else if (wr) begin
      case (idx)
        REG_ENTRY_WIDTH:  entry_width_r  <= pwdata[ENTRY_W_BITS-1:0];
        REG_COMPARE_MODE: compare_mode_r <= pwdata[MODE_BITS-1:0];
        REG_LOW_VALUE:    low_value_r    <= pwdata[VAL_BITS-1:0];
        REG_HIGH_VALUE:   high_value_r   <= pwdata[VAL_BITS-1:0];
        REG_ENTRY_COUNT:  entry_count_r  <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENTRY_WIDTH:  prdata = APB_DATA_BITS'(entry_width_r);
      REG_COMPARE_MODE: prdata = APB_DATA_BITS'(compare_mode_r);
      REG_LOW_VALUE:    prdata = APB_DATA_BITS'(low_value_r);
      REG_HIGH_VALUE:   prdata = APB_DATA_BITS'(high_value_r);
      REG_ENTRY_COUNT:  prdata = APB_DATA_BITS'(entry_count_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.entry_width  = entry_width_r;
  assign cfg.compare_mode = compare_mode_r;
  assign cfg.low_value    = low_value_r;
  assign cfg.high_value   = high_value_r;
  assign cfg.entry_count  = entry_count_r;
  // new width or count starts an aligned column
  assign cfg.restart      = wr && (idx == REG_ENTRY_WIDTH || idx == REG_ENTRY_COUNT);

endmodule

/* hw/rtl/bpcs_window.sv */
module bpcs_window import bpcs_pkg::*; #(
  parameter int WORD_BITS      = 32,
  parameter int MAX_ENTRY_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  win_ctrl_t                 ctrl,
  input  logic [WORD_BITS-1:0]      word,
  input  logic [ENTRY_W_BITS-1:0]   width,
  output logic [MAX_ENTRY_BITS-1:0] entry,
  output logic                      has_entry
);

  localparam int WIN_BITS   = WORD_BITS + MAX_ENTRY_BITS - 1;
  localparam int AVAIL_BITS = $clog2(WIN_BITS + 1);

  logic [WIN_BITS-1:0]   win_r, win_nxt;
  logic [AVAIL_BITS-1:0] avail_r, avail_nxt;

  assign has_entry = avail_r >= AVAIL_BITS'(width);
  assign entry     = win_r[MAX_ENTRY_BITS-1:0] & ~({MAX_ENTRY_BITS{1'b1}} << width);

  always_comb begin
    win_nxt   = win_r;
    avail_nxt = avail_r;
    if (ctrl.clear) begin
      win_nxt   = '0;
      avail_nxt = '0;
    end else if (ctrl.load) begin
      // leftover bits stay low, the new word lands above them
      win_nxt   = win_r | (WIN_BITS'(word) << avail_r);
      avail_nxt = avail_r + AVAIL_BITS'(WORD_BITS);
    end else if (ctrl.step) begin
      win_nxt   = win_r >> width;
      avail_nxt = avail_r - AVAIL_BITS'(width);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      avail_r <= '0;
    end else begin
      win_r   <= win_nxt;
      avail_r <= avail_nxt;
    end
  end

endmodule

/* hw/rtl/bpcs_pred.sv */
module bpcs_pred import bpcs_pkg::*; #(
  parameter int MAX_ENTRY_BITS = 31
) (
  input  logic [MAX_ENTRY_BITS-1:0] value,
  input  logic [MODE_BITS-1:0]      mode,
  input  logic [VAL_BITS-1:0]       low_value,
  input  logic [VAL_BITS-1:0]       high_value,
  output logic                      match
);

  logic [VAL_BITS-1:0] v;

  assign v = VAL_BITS'(value);

  always_comb begin
    case (mode)
      CMP_EQ:    match = (v == low_value);
      CMP_NE:    match = (v != low_value);
      CMP_RANGE: match = (v >= low_value) && (v <= high_value);
      default:   match = 1'b0;
    endcase
  end

endmodule

/* hw/rtl/bit_packed_column_scan.sv */
// Predicate scan over a bit-packed column of unsigned entries.
// in_ch carries 32-bit words of the column, LSB first; entries of
// entry_width bits are packed back to back and may straddle words.
// out_ch carries one transfer per complete entry: match, entry_index and
// last_entry, which flags entry number entry_count - 1.
// Registers are written over the APB port at byte address 4*i.
// A word is accepted in ST_IDLE; ST_SCAN then takes one entry per cycle
// through the shared window shifter while the result register is free,
// and returns to ST_IDLE once the word is exhausted, or when the entry
// that ends the column is emitted. in_ch.ready is high only between words.
// The first result of a word is emitted from ST_SCAN into the result register.
// The result register lets a word be accepted while the last result waits.
// When out_ch stalls, the scan holds until the result register drains.
// Reset (or a write of entry_width or entry_count) empties the bit buffer
// and the entry counter. Words arriving after the column is complete are
// taken and dropped.
`include "assert_macros.svh"

module bit_packed_column_scan import bpcs_pkg::*; #(
  parameter int WORD_BITS      = 32,
  parameter int MAX_ENTRY_BITS = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  bpcs_word_if.sink                in_ch,
  bpcs_result_if.source            out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_t                      cfg;
  win_ctrl_t                 ctrl;
  scan_state_t               state_r, state_nxt;
  logic [ENTRY_W_BITS-1:0]   eff_w;
  logic [MAX_ENTRY_BITS-1:0] entry;
  logic                      has_entry;
  logic                      match;
  logic                      emit;
  logic                      last_hit;
  logic                      slot_free;
  logic [COUNT_BITS-1:0]     done_r, done_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_match_r;
  logic [COUNT_BITS-1:0]     out_index_r;
  logic                      out_last_r;

  bpcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpcs_window #(
    .WORD_BITS      (WORD_BITS),
    .MAX_ENTRY_BITS (MAX_ENTRY_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .word      (in_ch.packed_word),
    .width     (eff_w),
    .entry     (entry),
    .has_entry (has_entry)
  );

  bpcs_pred #(
    .MAX_ENTRY_BITS (MAX_ENTRY_BITS)
  ) u_pred (
    .value      (entry),
    .mode       (cfg.compare_mode),
    .low_value  (cfg.low_value),
    .high_value (cfg.high_value),
    .match      (match)
  );

  always_comb begin
    if (cfg.entry_width == '0) begin
      eff_w = ENTRY_W_BITS'(1);
    end else if (cfg.entry_width > ENTRY_W_BITS'(MAX_ENTRY_BITS)) begin
      eff_w = ENTRY_W_BITS'(MAX_ENTRY_BITS);
    end else begin
      eff_w = cfg.entry_width;
    end
  end

  assign last_hit    = (done_r + COUNT_BITS'(1)) == cfg.entry_count;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (done_r == cfg.entry_count) begin
            ctrl.clear = 1'b1;
          end else begin
            ctrl.load = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!has_entry) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          emit      = 1'b1;
          ctrl.step = 1'b1;
          if (last_hit) begin
            // padding after the final entry is dropped
            ctrl.clear = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg.restart) begin
      ctrl.clear = 1'b1;
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (cfg.restart) begin
      done_nxt = '0;
    end else if (emit) begin
      done_nxt = done_r + COUNT_BITS'(1);
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_match_r <= match;
      out_index_r <= done_r;
      out_last_r  <= last_hit;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match       = out_match_r;
  assign out_ch.entry_index = out_index_r;
  assign out_ch.last_entry  = out_last_r;

  // results are only produced by the scan sequencer
  `BPCS_ASSERT(a_emit_from_scan, $rose(out_valid_r) |-> $past(state_r == ST_SCAN))
  // between words the buffer never holds a whole entry
  `BPCS_ASSERT_NEVER(a_idle_no_entry, state_r == ST_IDLE && has_entry)
  // a completed column leaves nothing buffered
  `BPCS_ASSERT(a_last_clears, (emit && last_hit && !cfg.restart) |=> !has_entry)

endmodule
